// ----- rtl/mbrtu_pkg.sv -----
// shared types, constants and crc helper for the modbus rtu two-register read unit
package mbrtu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] FUNC_READ = 8'h03;
   localparam logic [7:0] REG_COUNT = 8'h02;
   localparam logic [7:0] BYTE_COUNT = 8'h04;

   localparam logic [7:0] DEV_ADDR_RESET = 8'h01;
   localparam logic [15:0] TIMEOUT_RESET = 16'd400;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEV_ADDR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = CSR_INDEX_W'(1);

   // reply byte positions
   localparam logic [3:0] RX_ADDR = 4'd0;
   localparam logic [3:0] RX_FUNC = 4'd1;
   localparam logic [3:0] RX_COUNT = 4'd2;
   localparam logic [3:0] RX_HUM_HI = 4'd3;
   localparam logic [3:0] RX_HUM_LO = 4'd4;
   localparam logic [3:0] RX_TEMP_HI = 4'd5;
   localparam logic [3:0] RX_TEMP_LO = 4'd6;
   localparam logic [3:0] RX_CRC_LO = 4'd7;
   localparam logic [3:0] RX_CRC_HI = 4'd8;

   // request byte positions
   localparam logic [2:0] TX_ADDR = 3'd0;
   localparam logic [2:0] TX_FUNC = 3'd1;
   localparam logic [2:0] TX_COUNT_LO = 3'd5;
   localparam logic [2:0] TX_CRC_LO = 3'd6;
   localparam logic [2:0] TX_CRC_HI = 3'd7;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_HEADER  = 2'd2,
      ST_CRC     = 2'd3
   } status_type;

   typedef enum logic {
      KIND_TX     = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic              is_start;
      logic [7:0]        addr;
      status_type        status;
      logic [15:0]       humidity;
      logic signed [15:0] temperature;
   } cmd_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/mbrtu_front.sv -----
// front part: config registers, reply tracking, command generation
module mbrtu_front import mbrtu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_rx_byte,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push,
   output cmd_type                push_cmd,
   input  logic                   queue_full
);

   logic [7:0]  addr_ff;
   logic [15:0] timeout_ff;

   logic        awaiting_ff, awaiting_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        header_good_ff, header_good_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] temp_ff, temp_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic        accept;
   logic [15:0] elapsed_sum;
   action_type  act;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign act = action_type'(req_action);
   assign elapsed_sum = elapsed_ff + 16'd1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= DEV_ADDR_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEV_ADDR) begin
            addr_ff <= csr_data[7:0];
         end else if (csr_index == CSR_TIMEOUT) begin
            timeout_ff <= csr_data[15:0];
         end
      end
   end

   always_comb begin
      logic clear;
      clear = 1'b0;
      awaiting_in = awaiting_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      header_good_in = header_good_ff;
      elapsed_in = elapsed_ff;
      hum_in = hum_ff;
      temp_in = temp_ff;
      crc_low_in = crc_low_ff;
      push = 1'b0;
      push_cmd.is_start = 1'b0;
      push_cmd.addr = addr_ff;
      push_cmd.status = ST_OK;
      push_cmd.humidity = 16'h0000;
      push_cmd.temperature = 16'sh0000;
      if (accept) begin
         case (act)
            ACT_START: begin
               push = 1'b1;
               push_cmd.is_start = 1'b1;
               clear = 1'b1;
            end
            ACT_TICK: begin
               if (awaiting_ff) begin
                  if (elapsed_sum >= timeout_ff) begin
                     push = 1'b1;
                     push_cmd.status = ST_TIMEOUT;
                     clear = 1'b1;
                  end else begin
                     elapsed_in = elapsed_sum;
                  end
               end
            end
            ACT_BYTE: begin
               if (awaiting_ff) begin
                  if (count_ff < RX_CRC_LO) begin
                     crc_in = crc16_byte(crc_ff, req_rx_byte);
                  end
                  case (count_ff)
                     RX_ADDR: begin
                        if (req_rx_byte != addr_ff) header_good_in = 1'b0;
                     end
                     RX_FUNC: begin
                        if (req_rx_byte != FUNC_READ) header_good_in = 1'b0;
                     end
                     RX_COUNT: begin
                        if (req_rx_byte != BYTE_COUNT) header_good_in = 1'b0;
                     end
                     RX_HUM_HI: hum_in = {req_rx_byte, hum_ff[7:0]};
                     RX_HUM_LO: hum_in = {hum_ff[15:8], req_rx_byte};
                     RX_TEMP_HI: temp_in = {req_rx_byte, temp_ff[7:0]};
                     RX_TEMP_LO: temp_in = {temp_ff[15:8], req_rx_byte};
                     RX_CRC_LO: crc_low_in = req_rx_byte;
                     default: ;
                  endcase
                  if (count_ff == RX_CRC_HI) begin
                     push = 1'b1;
                     clear = 1'b1;
                     if (!header_good_ff) begin
                        push_cmd.status = ST_HEADER;
                     end else if ({req_rx_byte, crc_low_ff} != crc_ff) begin
                        push_cmd.status = ST_CRC;
                     end else begin
                        push_cmd.humidity = hum_ff;
                        push_cmd.temperature = temp_ff;
                     end
                  end else begin
                     count_in = count_ff + 4'd1;
                  end
               end
            end
            default: ;
         endcase
      end
      if (clear) begin
         awaiting_in = (act == ACT_START);
         count_in = 4'd0;
         crc_in = CRC_INIT;
         header_good_in = 1'b1;
         elapsed_in = 16'h0000;
         hum_in = 16'h0000;
         temp_in = 16'h0000;
         crc_low_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         count_ff <= 4'd0;
         crc_ff <= CRC_INIT;
         header_good_ff <= 1'b1;
         elapsed_ff <= 16'h0000;
         hum_ff <= 16'h0000;
         temp_ff <= 16'h0000;
         crc_low_ff <= 8'h00;
      end else begin
         awaiting_ff <= awaiting_in;
         count_ff <= count_in;
         crc_ff <= crc_in;
         header_good_ff <= header_good_in;
         elapsed_ff <= elapsed_in;
         hum_ff <= hum_in;
         temp_ff <= temp_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

// ----- rtl/mbrtu_queue.sv -----
// short command queue between front and back parts
module mbrtu_queue import mbrtu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd = mem_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/mbrtu_back.sv -----
// back part: expands commands into request bytes or one status, output register
module mbrtu_back import mbrtu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic [1:0]        rsp_status,
   output logic [15:0]       rsp_humidity_raw,
   output logic signed [15:0] rsp_temperature_raw,
   output logic              rsp_last
);

   logic              valid_ff;
   logic              kind_ff, kind_in;
   logic [7:0]        tx_ff, tx_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       hum_ff, hum_in;
   logic signed [15:0] temp_ff, temp_in;
   logic              last_ff, last_in;
   logic [2:0]        idx_ff, idx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              load;
   logic [15:0]       crc_base;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign crc_base = (idx_ff == TX_ADDR) ? CRC_INIT : crc_ff;

   always_comb begin
      kind_in = KIND_STATUS;
      tx_in = 8'h00;
      status_in = head_cmd.status;
      hum_in = head_cmd.humidity;
      temp_in = head_cmd.temperature;
      last_in = 1'b1;
      idx_in = idx_ff;
      crc_in = crc_ff;
      pop = 1'b0;
      if (head_cmd.is_start) begin
         kind_in = KIND_TX;
         status_in = ST_OK;
         hum_in = 16'h0000;
         temp_in = 16'sh0000;
         last_in = (idx_ff == TX_CRC_HI);
         case (idx_ff)
            TX_ADDR: tx_in = head_cmd.addr;
            TX_FUNC: tx_in = FUNC_READ;
            TX_COUNT_LO: tx_in = REG_COUNT;
            TX_CRC_LO: tx_in = crc_ff[7:0];
            TX_CRC_HI: tx_in = crc_ff[15:8];
            default: tx_in = 8'h00;
         endcase
         if (load) begin
            if (idx_ff < TX_CRC_LO) begin
               crc_in = crc16_byte(crc_base, tx_in);
            end
            if (idx_ff == TX_CRC_HI) begin
               idx_in = TX_ADDR;
               pop = 1'b1;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end else begin
         pop = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= TX_ADDR;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (load) begin
         kind_ff <= kind_in;
         tx_ff <= tx_in;
         status_ff <= status_in;
         hum_ff <= hum_in;
         temp_ff <= temp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_tx_byte = tx_ff;
   assign rsp_status = status_ff;
   assign rsp_humidity_raw = hum_ff;
   assign rsp_temperature_raw = temp_ff;
   assign rsp_last = last_ff;

endmodule

// ----- rtl/modbus_rtu_read_two_registers_unit.sv -----
// top level of the modbus rtu two-register read unit
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  action, rx_byte
//  rsp_     out        rsp_valid/rsp_stall  kind, tx_byte, status, humidity_raw,
//                                           temperature_raw, last
//  csr_     in         csr_valid/csr_ready  index, data (0 device address, 1 timeout)
//
// a received byte or tick request is handled in the front part; a start
// request puts one command in the queue, which the back part turns into 8
// request bytes at one per cycle while rsp_stall is low.
// requests are stalled only while the command queue is full.
// reset is synchronous and returns the unit to idle with default registers.
module modbus_rtu_read_two_registers_unit import mbrtu_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_tx_byte,
   output logic [1:0]             rsp_status,
   output logic [15:0]            rsp_humidity_raw,
   output logic signed [15:0]     rsp_temperature_raw,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic    push, full, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   mbrtu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_rx_byte(req_rx_byte),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   mbrtu_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   mbrtu_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_status         (rsp_status),
      .rsp_humidity_raw   (rsp_humidity_raw),
      .rsp_temperature_raw(rsp_temperature_raw),
      .rsp_last           (rsp_last)
   );

endmodule

// ----- sim/modbus_rtu_read_two_registers_checker.sv -----
// checker for the modbus rtu two-register read unit: predicts every result and compares it
module mbrtu_read_checker import mbrtu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_kind,
   input  logic [7:0]             rsp_tx_byte,
   input  logic [1:0]             rsp_status,
   input  logic [15:0]            rsp_humidity_raw,
   input  logic signed [15:0]     rsp_temperature_raw,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     checked_count,
   output int                     status_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      status_type  status;
      logic [15:0] humidity;
      logic [15:0] temperature;
      logic        last;
   } bus_result_type;

   bus_result_type expected_results[$];

   // register copies
   logic [7:0]  dev_addr;
   logic [15:0] timeout_limit;

   // open transaction
   logic        awaiting;
   logic [3:0]  rx_count;
   logic [15:0] crc_run;
   logic        hdr_ok;
   logic [15:0] ticks_seen;
   logic [15:0] hum_cap;
   logic [15:0] temp_cap;
   logic [7:0]  crc_lo_cap;

   // bit-serial form: feedback is the low crc bit xor the next data bit
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] octet);
      logic [15:0] acc;
      acc = crc;
      for (int b = 0; b < 8; b++) begin
         acc = {1'b0, acc[15:1]} ^ ((acc[0] ^ octet[b]) ? CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic void drop_transaction();
      awaiting = 1'b0;
      rx_count = '0;
      crc_run = CRC_INIT;
      hdr_ok = 1'b1;
      ticks_seen = '0;
      hum_cap = '0;
      temp_cap = '0;
      crc_lo_cap = '0;
   endfunction

   function automatic void queue_result(input kind_type kind, input logic [7:0] tx,
                                        input status_type st, input logic [15:0] hum,
                                        input logic [15:0] temp, input logic last);
      bus_result_type item;
      item.kind = kind;
      item.tx_byte = tx;
      item.status = st;
      item.humidity = hum;
      item.temperature = temp;
      item.last = last;
      expected_results.push_back(item);
   endfunction

   task automatic flag_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, what);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("result %0d %s got %h want %h", checked_count, name, got,
                                 want));
      end
   endtask

   task automatic predict_request(input logic [1:0] act, input logic [7:0] octet);
      logic [7:0]  frame [8];
      logic [15:0] crc;
      case (act)
         ACT_START: begin
            frame[0] = dev_addr;
            frame[1] = FUNC_READ;
            frame[2] = 8'h00;
            frame[3] = 8'h00;
            frame[4] = 8'h00;
            frame[5] = REG_COUNT;
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = crc_step(crc, frame[i]);
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
               queue_result(KIND_TX, frame[i], ST_OK, 16'h0000, 16'h0000, i == 7);
            end
            // a start drops whatever was open, without status
            drop_transaction();
            awaiting = 1'b1;
         end
         ACT_TICK: begin
            if (awaiting) begin
               ticks_seen = ticks_seen + 16'd1;
               if (ticks_seen >= timeout_limit) begin
                  queue_result(KIND_STATUS, 8'h00, ST_TIMEOUT, 16'h0000, 16'h0000, 1'b1);
                  drop_transaction();
               end
            end
         end
         ACT_BYTE: begin
            if (awaiting) begin
               if (rx_count < RX_CRC_LO) crc_run = crc_step(crc_run, octet);
               case (rx_count)
                  RX_ADDR:    if (octet != dev_addr) hdr_ok = 1'b0;
                  RX_FUNC:    if (octet != FUNC_READ) hdr_ok = 1'b0;
                  RX_COUNT:   if (octet != BYTE_COUNT) hdr_ok = 1'b0;
                  RX_HUM_HI:  hum_cap[15:8] = octet;
                  RX_HUM_LO:  hum_cap[7:0] = octet;
                  RX_TEMP_HI: temp_cap[15:8] = octet;
                  RX_TEMP_LO: temp_cap[7:0] = octet;
                  RX_CRC_LO:  crc_lo_cap = octet;
                  default: ;
               endcase
               if (rx_count != RX_CRC_HI) begin
                  rx_count = rx_count + 4'd1;
               end else begin
                  // header errors win over checksum errors
                  if (!hdr_ok) begin
                     queue_result(KIND_STATUS, 8'h00, ST_HEADER, 16'h0000, 16'h0000, 1'b1);
                  end else if ({octet, crc_lo_cap} != crc_run) begin
                     queue_result(KIND_STATUS, 8'h00, ST_CRC, 16'h0000, 16'h0000, 1'b1);
                  end else begin
                     queue_result(KIND_STATUS, 8'h00, ST_OK, hum_cap, temp_cap, 1'b1);
                  end
                  drop_transaction();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      bus_result_type want;
      if (expected_results.size() == 0) begin
         flag_mismatch($sformatf("result with nothing expected: kind %0d tx %h status %0d",
                                 rsp_kind, rsp_tx_byte, rsp_status));
      end else begin
         want = expected_results.pop_front();
         checked_count++;
         if (want.kind == KIND_STATUS) status_count++;
         compare_field("kind", 16'(rsp_kind), 16'(want.kind));
         compare_field("tx_byte", 16'(rsp_tx_byte), 16'(want.tx_byte));
         compare_field("status", 16'(rsp_status), 16'(want.status));
         compare_field("humidity_raw", rsp_humidity_raw, want.humidity);
         compare_field("temperature_raw", rsp_temperature_raw, want.temperature);
         compare_field("last", 16'(rsp_last), 16'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dev_addr = DEV_ADDR_RESET;
         timeout_limit = TIMEOUT_RESET;
         drop_transaction();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEV_ADDR) begin
               dev_addr = csr_data[7:0];
            end else if (csr_index == CSR_TIMEOUT) begin
               timeout_limit = csr_data;
            end
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_request(req_action, req_rx_byte);
      end
      pending <= expected_results.size();
   end

endmodule

// ----- sim/modbus_rtu_read_two_registers_unit_test.sv -----
// testbench top for the modbus rtu two-register read unit: stimulus, flow control and verdict
module modbus_rtu_read_two_registers_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mbrtu_pkg::*;

   localparam logic [1:0] ACT_RESERVED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int PHASE_REQUESTS = 14;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_action = '0;
   logic [7:0]             req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_kind;
   logic [7:0]             rsp_tx_byte;
   logic [1:0]             rsp_status;
   logic [15:0]            rsp_humidity_raw;
   logic signed [15:0]     rsp_temperature_raw;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int fail_count;
   int pending;
   int checked_count;
   int status_count;

   int req_gap_max = 5;
   int rsp_gap_max = 5;
   int rsp_hold_cycles = 0;
   int tick_odds = 0;
   int request_total = 0;
   int start_total = 0;
   int setting_total = 0;

   modbus_rtu_read_two_registers_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_status          (rsp_status),
      .rsp_humidity_raw    (rsp_humidity_raw),
      .rsp_temperature_raw (rsp_temperature_raw),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   mbrtu_read_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_status          (rsp_status),
      .rsp_humidity_raw    (rsp_humidity_raw),
      .rsp_temperature_raw (rsp_temperature_raw),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked_count       (checked_count),
      .status_count        (status_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("modbus_rtu_read_two_registers_unit_test NOT OK");
      $finish;
   end

   // result side: random pause after each accepted result, or a long hold-off on demand
   initial begin : receiver
      int unsigned pause_left;
      pause_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            pause_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (rsp_valid && !rsp_stall) begin
            pause_left = $urandom_range(rsp_gap_max);
         end
         if (pause_left != 0) begin
            rsp_stall <= 1'b1;
            pause_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [7:0] octet);
      int unsigned gap;
      gap = $urandom_range(req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= octet;
      do @(posedge clock); while (req_stall);
      request_total++;
      if (act == ACT_START) start_total++;
   endtask

   // sends the first keep bytes of a reply frame, ticks sprinkled in between
   task automatic send_reply(input logic [7:0] addr, input logic [7:0] fcode,
                             input logic [7:0] cnt, input logic [15:0] hum,
                             input logic [15:0] temp, input logic [15:0] flip,
                             input int unsigned keep);
      logic [7:0]  frame [9];
      logic [15:0] crc;
      frame = '{addr, fcode, cnt, hum[15:8], hum[7:0], temp[15:8], temp[7:0], 8'h00, 8'h00};
      crc = CRC_INIT;
      for (int i = 0; i < 7; i++) crc = crc16_byte(crc, frame[i]);
      crc = crc ^ flip;
      frame[7] = crc[7:0];
      frame[8] = crc[15:8];
      for (int i = 0; i < keep; i++) begin
         if (tick_odds != 0 && $urandom_range(tick_odds - 1) == 0) begin
            send_request(ACT_TICK, 8'($urandom_range(255)));
         end
         send_request(ACT_BYTE, frame[i]);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] addr, input logic [15:0] limit);
      wait_drain();
      write_register(CSR_DEV_ADDR, 16'(addr));
      write_register(CSR_TIMEOUT, limit);
      setting_total++;
   endtask

   task automatic random_transaction();
      int unsigned pick;
      logic [15:0] hum;
      logic [15:0] temp;
      logic [7:0]  addr;
      logic [7:0]  fcode;
      logic [7:0]  cnt;
      pick = $urandom_range(9);
      hum = 16'($urandom);
      temp = 16'($urandom);
      if ($urandom_range(7) == 0) hum = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(7) == 0) temp = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      addr = u_check.dev_addr;
      fcode = FUNC_READ;
      cnt = BYTE_COUNT;
      case (pick)
         0: begin
            // stray traffic, reserved codes included
            repeat ($urandom_range(3, 1)) begin
               send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
         end
         1: begin
            // cut short: the next start aborts it or ticks time it out
            send_request(ACT_START, 8'($urandom_range(255)));
            send_reply(addr, fcode, cnt, hum, temp, 16'h0000, $urandom_range(8));
         end
         2: begin
            send_request(ACT_START, 8'($urandom_range(255)));
            case ($urandom_range(2))
               0: addr = addr ^ 8'($urandom_range(255, 1));
               1: fcode = fcode ^ 8'($urandom_range(255, 1));
               default: cnt = cnt ^ 8'($urandom_range(255, 1));
            endcase
            send_reply(addr, fcode, cnt, hum, temp, 16'($urandom_range(1)), 9);
         end
         3: begin
            send_request(ACT_START, 8'($urandom_range(255)));
            send_reply(addr, fcode, cnt, hum, temp, 16'($urandom_range(65535, 1)), 9);
         end
         default: begin
            send_request(ACT_START, 8'($urandom_range(255)));
            send_reply(addr, fcode, cnt, hum, temp, 16'h0000, 9);
         end
      endcase
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned goal;
      goal = request_total + count;
      while (request_total < goal) random_transaction();
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle traffic, abort, extremes, header precedence, timeouts
      send_request(ACT_BYTE, 8'hFF);
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_RESERVED, 8'hA5);
      send_request(ACT_START, 8'h00);
      send_request(ACT_START, 8'h00);
      send_reply(DEV_ADDR_RESET, FUNC_READ, BYTE_COUNT, 16'hFFFF, 16'h8000, 16'h0000, 9);
      send_request(ACT_START, 8'h00);
      // wrong address and wrong checksum together: header status expected
      send_reply(8'h00, FUNC_READ, BYTE_COUNT, 16'h0000, 16'h7FFF, 16'h0001, 9);
      set_config(8'hFF, 16'd1);
      send_request(ACT_START, 8'hFF);
      send_request(ACT_TICK, 8'hFF);
      set_config(8'h80, 16'd0);
      send_request(ACT_START, 8'h5A);
      send_request(ACT_TICK, 8'h5A);

      // random: well-formed replies dominate, with broken and cut-short ones mixed in
      set_config(8'hFF, 16'hFFFF);
      tick_odds = 4;
      run_phase(PHASE_REQUESTS / 2);
      wait_drain();
      run_phase(PHASE_REQUESTS / 2);

      set_config(8'h00, 16'd3);
      req_gap_max = 0;
      rsp_gap_max = 0;
      tick_odds = 3;
      run_phase(PHASE_REQUESTS);

      set_config(8'($urandom_range(255)), 16'($urandom_range(30, 4)));
      req_gap_max = 5;
      rsp_gap_max = 5;
      tick_odds = 4;
      // fill the command queue while the result side is held off
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (6) send_request(ACT_START, 8'($urandom_range(255)));
      run_phase(PHASE_REQUESTS);

      set_config(8'($urandom_range(255)), 16'($urandom_range(10, 2)));
      req_gap_max = 0;
      tick_odds = 2;
      run_phase(PHASE_REQUESTS);

      wait_drain();
      $display("covered %0d requests (%0d starts) under %0d register settings, with aborts,",
               request_total, start_total, setting_total);
      $display("timeouts, bad headers and bad checksums; %0d results compared, %0d status",
               checked_count, status_count);
      if (fail_count == 0 && pending == 0) begin
         $display("modbus_rtu_read_two_registers_unit_test OK");
      end else begin
         $display("modbus_rtu_read_two_registers_unit_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mbrtu_pkg.sv
rtl/mbrtu_front.sv
rtl/mbrtu_queue.sv
rtl/mbrtu_back.sv
rtl/modbus_rtu_read_two_registers_unit.sv
sim/modbus_rtu_read_two_registers_checker.sv
sim/modbus_rtu_read_two_registers_unit_test.sv
